FILE: rtl/bhs_pkg.sv
// Package for the bounded history stack: sizes, request and result types, codes.
`default_nettype none

package bhs_pkg;

    // Sizing
    localparam int CAPACITY    = 16;
    localparam int ENTRY_WIDTH = 32;
    localparam int VALUE_W     = 32;
    localparam int DEPTH_W     = 8;
    localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int SUM_W       = $clog2(2 * CAPACITY);

    // Request kinds; the fourth code is a no-op
    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_PEEK = 2'd2
    } req_kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [VALUE_W-1:0] entry_value;
        logic [DEPTH_W-1:0] depth;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        status_t            status;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/bounded_history_stack.sv
// Top level of the bounded history stack: ring memory, pointer and count logic.
//
//  channel  | ports                  | transfer
//  ---------+------------------------+-------------------------------------
//  request  | start, busy, request   | clock edge with start high, busy low
//  result   | done, result           | clock edge ending the done cycle
//
// A request is accepted in any cycle; busy never rises.
// Its result appears with done in the cycle after the transfer, since the entry
// memory has a registered read port.
// Pointer and count update at the transfer edge, so the next request sees them.
// A pushed entry is readable by a request in the next cycle.
// Reset clears pointer, count and done; memory contents are not cleared.
// The receiver cannot stall: every result is shown for one cycle only.
`default_nettype none

module bounded_history_stack (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire bhs_pkg::req_t request,
    output logic               done,
    output bhs_pkg::rsp_t      result
);
    import bhs_pkg::*;

    // Entry storage
    logic [ENTRY_WIDTH-1:0] mem [CAPACITY];

    logic [SLOT_W-1:0]      top_slot_reg, top_slot_next;
    logic [COUNT_W-1:0]     entry_count_reg, entry_count_next;
    logic                   done_reg;
    logic                   hit_reg, hit_next;
    status_t                status_reg, status_next;
    logic [ENTRY_WIDTH-1:0] rd_data_reg;

    logic                   accept;
    logic                   wr_en;
    logic                   rd_en;
    logic [COUNT_W-1:0]     back;
    logic [SUM_W-1:0]       sum_raw;
    logic [SUM_W-1:0]       sum_wrap;
    logic [SLOT_W-1:0]      slot_sel;
    logic [SLOT_W-1:0]      top_inc;
    logic                   depth_bad;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Slot a given number of places below the top, modulo capacity
    always_comb
    begin
        if (req_kind_t'(request.req_type) == REQ_PEEK)
            back = COUNT_W'(request.depth);
        else
            back = COUNT_W'(1);
        sum_raw = SUM_W'(top_slot_reg) + SUM_W'(CAPACITY) - SUM_W'(back);
        if (sum_raw >= SUM_W'(CAPACITY))
            sum_wrap = sum_raw - SUM_W'(CAPACITY);
        else
            sum_wrap = sum_raw;
        slot_sel = SLOT_W'(sum_wrap);
    end

    // Next push slot
    always_comb
    begin
        if (top_slot_reg == SLOT_W'(CAPACITY - 1))
            top_inc = '0;
        else
            top_inc = top_slot_reg + SLOT_W'(1);
    end

    // Peek depth check against the count, done at the wider width
    assign depth_bad = (request.depth == '0) ||
                       ({{COUNT_W{1'b0}}, request.depth} >
                        {{DEPTH_W{1'b0}}, entry_count_reg});

    // Request decode: pointer, count and result status
    always_comb
    begin
        top_slot_next    = top_slot_reg;
        entry_count_next = entry_count_reg;
        hit_next         = 1'b0;
        status_next      = ST_OK;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        case (req_kind_t'(request.req_type))
            REQ_PUSH:
            begin
                wr_en         = accept;
                top_slot_next = top_inc;
                if (entry_count_reg != COUNT_W'(CAPACITY))
                    entry_count_next = entry_count_reg + COUNT_W'(1);
            end
            REQ_POP:
            begin
                if (entry_count_reg == '0)
                    status_next = ST_EMPTY;
                else
                begin
                    rd_en            = accept;
                    hit_next         = 1'b1;
                    top_slot_next    = slot_sel;
                    entry_count_next = entry_count_reg - COUNT_W'(1);
                end
            end
            REQ_PEEK:
            begin
                if (entry_count_reg == '0)
                    status_next = ST_EMPTY;
                else if (depth_bad)
                    status_next = ST_RANGE;
                else
                begin
                    rd_en    = accept;
                    hit_next = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_slot_reg    <= '0;
            entry_count_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                top_slot_reg    <= top_slot_next;
                entry_count_reg <= entry_count_next;
            end
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[top_slot_reg] <= ENTRY_WIDTH'(request.entry_value);
        if (rd_en)
            rd_data_reg <= mem[slot_sel];
    end

    // Result drive
    assign done                = done_reg;
    assign result.result_value = hit_reg ? VALUE_W'(rd_data_reg) : '0;
    assign result.status       = status_reg;

    // Count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Every transfer gives exactly one result in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing result after transfer");

    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without transfer");

    // Pop of a non-empty stack removes one entry and returns ok
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_kind_t'(request.req_type) == REQ_POP && entry_count_reg != '0)
        |=> (entry_count_reg == $past(entry_count_reg) - COUNT_W'(1)) &&
            (result.status == ST_OK))
        else $error("pop did not remove one entry");

    // Push on a full stack keeps the count at capacity
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_kind_t'(request.req_type) == REQ_PUSH &&
         entry_count_reg == COUNT_W'(CAPACITY))
        |=> entry_count_reg == COUNT_W'(CAPACITY))
        else $error("full push changed the count");

endmodule

`default_nettype wire
